>>> hw/rtl/wpc_pkg.sv
package wpc_pkg;

    localparam int COORD_BITS         = 12;
    localparam int SAMPLE_BITS        = 24;
    localparam int CORDIC_STAGES_DEF  = 16;
    localparam int ATAN_ENTRIES       = 24;
    localparam int GUARD              = 16;
    localparam int GRID_BITS          = 13;
    localparam int STEP_BITS          = 32;
    localparam int W_BITS             = 32;
    localparam int CFG_INDEX_BITS     = 3;
    localparam int CFG_DATA_BITS      = 32;

    localparam logic [GRID_BITS-1:0] GRID_RESET = 13'd4096;
    // 1/K of the CORDIC gain, Q0.32
    localparam logic [31:0] INV_GAIN = 32'h9B74EDA8;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_GRID_WIDTH  = 3'd0,
        REG_GRID_HEIGHT = 3'd1,
        REG_CELL_STEP_X = 3'd2,
        REG_CELL_STEP_Y = 3'd3,
        REG_W_TURNS     = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic        [COORD_BITS-1:0]  pixel_x;
        logic        [COORD_BITS-1:0]  pixel_y;
        logic signed [SAMPLE_BITS-1:0] sample_real;
        logic signed [SAMPLE_BITS-1:0] sample_imag;
    } pix_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] result_real;
        logic signed [SAMPLE_BITS-1:0] result_imag;
    } res_t;

    // arctan(2^-k) in turns, Q0.32
    function automatic logic [31:0] atan_turn(input int k);
        logic [31:0] a;
        case (k)
            0:  a = 32'h20000000;
            1:  a = 32'h12E4051E;
            2:  a = 32'h09FB385B;
            3:  a = 32'h051111D4;
            4:  a = 32'h028B0D43;
            5:  a = 32'h0145D7E1;
            6:  a = 32'h00A2F61E;
            7:  a = 32'h00517C55;
            8:  a = 32'h0028BE53;
            9:  a = 32'h00145F2F;
            10: a = 32'h000A2F98;
            11: a = 32'h000517CC;
            12: a = 32'h00028BE6;
            13: a = 32'h000145F3;
            14: a = 32'h0000A2FA;
            15: a = 32'h0000517D;
            16: a = 32'h000028BE;
            17: a = 32'h0000145F;
            18: a = 32'h00000A30;
            19: a = 32'h00000518;
            20: a = 32'h0000028C;
            21: a = 32'h00000146;
            22: a = 32'h000000A3;
            23: a = 32'h00000051;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage

>>> hw/rtl/w_plane_phase_correction_top.sv
// Channel | Signals                      | Direction | Transaction when
// pix     | pix_valid, pix_ready, pix    | in        | pix_valid && pix_ready
// res     | res_valid, res_ready, res    | out       | res_valid && res_ready
// cfg     | cfg_we, cfg_index, cfg_data  | in        | cfg_we (no wait, no read-back)
//
// Pipeline: pixel offsets, direction cosines, squares, radicand, the 32-step square root,
// s, product and angle registers, quadrant pre-rotation, CORDIC stages, output register.
// Throughput: one transaction per cycle while res_ready does not hold the output.
// Stall: a single advance enable moves every stage; it drops only while the output
// register holds a result that res_ready has not taken, so nothing is lost or repeated.
// Reset: rst_n clears the valid chain and loads the register reset values.
module w_plane_phase_correction_top
    import wpc_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pix_valid,
    output logic                      pix_ready,
    input  pix_t                      pix,
    output logic                      res_valid,
    input  logic                      res_ready,
    output res_t                      res,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int SB  = SAMPLE_BITS;
    // signed offset width: pixel index against half the grid
    localparam int DW  = ((COORD_BITS > GRID_BITS - 1) ? COORD_BITS : GRID_BITS - 1) + 1;
    localparam int MW  = DW + STEP_BITS;          // |d| * step
    localparam int PW  = SB + 33;                 // sample * 1/K
    localparam int XW  = SB + GUARD + 2;          // CORDIC datapath
    localparam int RW  = 33;                      // angle residual
    localparam int QN  = 32;                      // square root digit steps
    localparam int SRW = 33;                      // square root remainder
    localparam int NST = 4 + QN + 4 + CORDIC_STAGES + 1;
    localparam int V_SQ  = 3 + QN;                // valid index: root ready
    localparam int V_QD  = V_SQ + 4;              // valid index: quadrant done
    localparam int OW  = XW - GUARD;

    localparam logic signed [XW-1:0] RND    = XW'(1) <<< (GUARD - 1);
    localparam logic signed [OW-1:0] SAT_HI = {3'b000, {(SB-1){1'b1}}};
    localparam logic signed [OW-1:0] SAT_LO = {3'b111, {(SB-1){1'b0}}};

    // item data carried alongside the root/angle pipeline
    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [SB-1:0] re;
        logic signed [SB-1:0] im;
        logic                 byp;
        logic                 rz;
    } car_t;

    // ---------------- configuration registers ----------------
    logic        [GRID_BITS-1:0] grid_w_reg;
    logic        [GRID_BITS-1:0] grid_h_reg;
    logic        [STEP_BITS-1:0] step_x_reg;
    logic        [STEP_BITS-1:0] step_y_reg;
    logic signed [W_BITS-1:0]    w_turns_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_w_reg  <= GRID_RESET;
            grid_h_reg  <= GRID_RESET;
            step_x_reg  <= '0;
            step_y_reg  <= '0;
            w_turns_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GRID_WIDTH:  grid_w_reg  <= cfg_data[GRID_BITS-1:0];
                REG_GRID_HEIGHT: grid_h_reg  <= cfg_data[GRID_BITS-1:0];
                REG_CELL_STEP_X: step_x_reg  <= cfg_data[STEP_BITS-1:0];
                REG_CELL_STEP_Y: step_y_reg  <= cfg_data[STEP_BITS-1:0];
                REG_W_TURNS:     w_turns_reg <= $signed(cfg_data[W_BITS-1:0]);
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic           adv;
    logic [NST-1:0] vld_reg;

    assign adv       = !vld_reg[NST-1] || res_ready;
    assign pix_ready = adv;
    assign res_valid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NST-2:0], pix_valid};
    end

    // ---------------- stage 1: pixel offsets from grid centre ----------------
    logic signed [DW-1:0] dx_s, dy_s;
    logic        [DW-1:0] dxa1_reg, dya1_reg;
    logic signed [SB-1:0] re1_reg, im1_reg;
    logic                 byp1_reg;

    assign dx_s = $signed(DW'(pix.pixel_x)) - $signed(DW'(grid_w_reg[GRID_BITS-1:1]));
    assign dy_s = $signed(DW'(pix.pixel_y)) - $signed(DW'(grid_h_reg[GRID_BITS-1:1]));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dxa1_reg <= dx_s[DW-1] ? DW'(-dx_s) : DW'(dx_s);
            dya1_reg <= dy_s[DW-1] ? DW'(-dy_s) : DW'(dy_s);
            re1_reg  <= pix.sample_real;
            im1_reg  <= pix.sample_imag;
            byp1_reg <= (w_turns_reg == '0) ||
                        (pix.sample_real == '0 && pix.sample_imag == '0);
        end
    end

    // ---------------- stage 2: direction cosines, gain compensation ----------------
    logic        [MW-1:0] magx2_reg, magy2_reg;
    logic signed [PW-1:0] gx2_reg, gy2_reg;
    logic signed [SB-1:0] re2_reg, im2_reg;
    logic                 byp2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            magx2_reg <= MW'(dxa1_reg) * MW'(step_x_reg);
            magy2_reg <= MW'(dya1_reg) * MW'(step_y_reg);
            gx2_reg   <= PW'(re1_reg) * $signed(PW'(INV_GAIN));
            gy2_reg   <= PW'(im1_reg) * $signed(PW'(INV_GAIN));
            re2_reg   <= re1_reg;
            im2_reg   <= im1_reg;
            byp2_reg  <= byp1_reg;
        end
    end

    // ---------------- stage 3: squares ----------------
    logic [63:0]          sqx_f, sqy_f;
    logic                 ovf3;
    logic [31:0]          sqx3_reg, sqy3_reg;
    logic signed [XW-1:0] x3_reg, y3_reg;
    logic signed [SB-1:0] re3_reg, im3_reg;
    logic                 byp3_reg;

    assign sqx_f = 64'(magx2_reg[31:0]) * 64'(magx2_reg[31:0]);
    assign sqy_f = 64'(magy2_reg[31:0]) * 64'(magy2_reg[31:0]);
    // a cosine of one or more on either axis leaves the sample alone
    assign ovf3  = (magx2_reg[MW-1:32] != '0) || (magy2_reg[MW-1:32] != '0);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqx3_reg <= sqx_f[63:32];
            sqy3_reg <= sqy_f[63:32];
            x3_reg   <= XW'($signed(gx2_reg[PW-1:GUARD]));
            y3_reg   <= XW'($signed(gy2_reg[PW-1:GUARD]));
            re3_reg  <= re2_reg;
            im3_reg  <= im2_reg;
            byp3_reg <= byp2_reg || ovf3;
        end
    end

    // ---------------- stage 4: r2 and radicand ----------------
    logic [32:0]    r2;
    logic [31:0]    sq_rem_unused;
    logic [SRW-1:0] sq_rem_reg  [0:QN];
    logic [31:0]    sq_root_reg [0:QN];
    logic [31:0]    sq_v_reg    [0:QN];
    car_t           sq_car_reg  [0:QN];

    assign r2 = {1'b0, sqx3_reg} + {1'b0, sqy3_reg};
    assign sq_rem_unused = '0;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // radicand is (2^32 - r2) * 2^32; only the upper word is nonzero
            sq_v_reg[0]       <= ~r2[31:0] + 32'd1;
            sq_rem_reg[0]     <= SRW'(sq_rem_unused);
            sq_root_reg[0]    <= '0;
            sq_car_reg[0].x   <= x3_reg;
            sq_car_reg[0].y   <= y3_reg;
            sq_car_reg[0].re  <= re3_reg;
            sq_car_reg[0].im  <= im3_reg;
            sq_car_reg[0].byp <= byp3_reg || r2[32];
            sq_car_reg[0].rz  <= (r2 == '0);
        end
    end

    // ---------------- square root: one result bit per stage ----------------
    for (genvar j = 0; j < QN; j++)
    begin : g_sqrt
        logic [SRW+1:0] remt;
        logic [SRW+1:0] trial;
        logic           ge;

        assign remt  = {sq_rem_reg[j], sq_v_reg[j][31:30]};
        assign trial = {1'b0, sq_root_reg[j], 2'b01};
        assign ge    = (remt >= trial);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_rem_reg[j+1]  <= ge ? SRW'(remt - trial) : SRW'(remt);
                sq_root_reg[j+1] <= {sq_root_reg[j][30:0], ge};
                sq_v_reg[j+1]    <= {sq_v_reg[j][29:0], 2'b00};
                sq_car_reg[j+1]  <= sq_car_reg[j];
            end
        end
    end

    // ---------------- phase: s = 1 - root, w * s, round to 16-bit angle ----------------
    logic [31:0]          s_reg;
    car_t                 s_car_reg;
    logic signed [64:0]   prod;
    logic [43:0]          prod_reg;
    car_t                 p_car_reg;
    logic [43:0]          prod_rnd;
    logic [15:0]          angle_reg;
    car_t                 a_car_reg;

    assign prod     = 65'(w_turns_reg) * $signed(65'(s_reg));
    assign prod_rnd = prod_reg + 44'h000_0800_0000;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // centre pixel: root is exactly one, so s is zero
            s_reg     <= sq_car_reg[QN].rz ? '0 : (~sq_root_reg[QN] + 32'd1);
            s_car_reg <= sq_car_reg[QN];
            prod_reg  <= prod[43:0];
            p_car_reg <= s_car_reg;
            angle_reg <= prod_rnd[43:28];
            a_car_reg <= p_car_reg;
        end
    end

    // ---------------- quadrant pre-rotation ----------------
    logic [31:0]          z_q, zq;
    logic [1:0]           quad;
    logic [31:0]          remz;
    logic signed [XW-1:0] xq, yq;

    logic signed [XW-1:0] cr_x   [0:CORDIC_STAGES];
    logic signed [XW-1:0] cr_y   [0:CORDIC_STAGES];
    logic signed [RW-1:0] cr_z   [0:CORDIC_STAGES];
    logic signed [SB-1:0] cr_re  [0:CORDIC_STAGES];
    logic signed [SB-1:0] cr_im  [0:CORDIC_STAGES];
    logic                 cr_byp [0:CORDIC_STAGES];

    // target is minus the angle, as Q0.32 turns
    assign z_q  = {~angle_reg + 16'd1, 16'h0000};
    assign zq   = z_q + 32'h2000_0000;
    assign quad = zq[31:30];
    assign remz = z_q - {quad, 30'b0};

    always_comb
    begin
        case (quad)
            2'd1:
            begin
                xq = -a_car_reg.y;
                yq = a_car_reg.x;
            end
            2'd2:
            begin
                xq = -a_car_reg.x;
                yq = -a_car_reg.y;
            end
            2'd3:
            begin
                xq = a_car_reg.y;
                yq = -a_car_reg.x;
            end
            default:
            begin
                xq = a_car_reg.x;
                yq = a_car_reg.y;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cr_x[0]   <= xq;
            cr_y[0]   <= yq;
            cr_z[0]   <= RW'($signed(remz));
            cr_re[0]  <= a_car_reg.re;
            cr_im[0]  <= a_car_reg.im;
            cr_byp[0] <= a_car_reg.byp;
        end
    end

    // ---------------- CORDIC micro-rotations ----------------
    for (genvar k = 0; k < CORDIC_STAGES; k++)
    begin : g_cordic
        logic signed [XW-1:0] dx, dy;
        logic signed [RW-1:0] at;

        assign dx = cr_y[k] >>> k;
        assign dy = cr_x[k] >>> k;
        assign at = RW'(atan_turn(k));

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (!cr_z[k][RW-1])
                begin
                    cr_x[k+1] <= cr_x[k] - dx;
                    cr_y[k+1] <= cr_y[k] + dy;
                    cr_z[k+1] <= cr_z[k] - at;
                end
                else
                begin
                    cr_x[k+1] <= cr_x[k] + dx;
                    cr_y[k+1] <= cr_y[k] - dy;
                    cr_z[k+1] <= cr_z[k] + at;
                end
                cr_re[k+1]  <= cr_re[k];
                cr_im[k+1]  <= cr_im[k];
                cr_byp[k+1] <= cr_byp[k];
            end
        end
    end

    // ---------------- round, saturate, output register ----------------
    logic signed [XW-1:0] xs, ys;
    logic signed [OW-1:0] xr, yr, xsat, ysat;
    res_t                 res_reg;

    assign xs   = cr_x[CORDIC_STAGES] + RND;
    assign ys   = cr_y[CORDIC_STAGES] + RND;
    assign xr   = $signed(xs[XW-1:GUARD]);
    assign yr   = $signed(ys[XW-1:GUARD]);
    assign xsat = (xr > SAT_HI) ? SAT_HI : ((xr < SAT_LO) ? SAT_LO : xr);
    assign ysat = (yr > SAT_HI) ? SAT_HI : ((yr < SAT_LO) ? SAT_LO : yr);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (cr_byp[CORDIC_STAGES])
            begin
                res_reg.result_real <= cr_re[CORDIC_STAGES];
                res_reg.result_imag <= cr_im[CORDIC_STAGES];
            end
            else
            begin
                res_reg.result_real <= xsat[SB-1:0];
                res_reg.result_imag <= ysat[SB-1:0];
            end
        end
    end

    assign res = res_reg;

    // ---------------- assertions ----------------
    // a held output freezes the whole valid chain
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("valid chain moved during stall");

    // zero plane w must mark the item for pass-through
    a_w_zero_byp: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] && (w_turns_reg == '0) |-> byp1_reg)
        else $error("zero w not bypassed");

    // radicand is at least 2^32, so the root is at least 2^16
    a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[V_SQ] && !sq_car_reg[QN].byp && !sq_car_reg[QN].rz
        |-> (sq_root_reg[QN][31:16] != '0))
        else $error("square root out of range");

    // residual after quadrant step is within an eighth turn
    a_resid_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[V_QD] |-> (cr_z[0] <= $signed(RW'(32'h2000_0000))) &&
                          (cr_z[0] >= -$signed(RW'(32'h2000_0000))))
        else $error("CORDIC residual out of range");

endmodule

>>> test/tb_top.sv
module tb_top;
    import wpc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Pipeline depth of the block: 41 + CORDIC stages. Used for drain waits only.
    localparam int LATENCY = 41 + CORDIC_STAGES_DEF;
    localparam int RANDOM_ITEMS = 1150;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      pix_valid = 1'b0;
    logic                      pix_ready;
    pix_t                      pix = '0;
    logic                      res_valid;
    logic                      res_ready = 1'b0;
    res_t                      res;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    w_plane_phase_correction_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Shadow copy of the configuration registers, updated with every write.
    logic [GRID_BITS-1:0] sh_width  = GRID_RESET;
    logic [GRID_BITS-1:0] sh_height = GRID_RESET;
    logic [STEP_BITS-1:0] sh_step_x = '0;
    logic [STEP_BITS-1:0] sh_step_y = '0;
    logic [W_BITS-1:0]    sh_w      = '0;

    res_t expected_pixels[$];
    int   mismatches = 0;

    // Idle rates in percent for each side; changed per phase.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Arc tangent table in turns (Q0.32), kept locally for the phase-screen predictor.
    localparam logic [31:0] ARCTAN_Q32 [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // Squared direction cosine, Q0.32; returns 0 when the cosine reaches one.
    function automatic bit dir_cos_sq(input logic [COORD_BITS-1:0] p,
                                      input logic [GRID_BITS-1:0] grid,
                                      input logic [31:0] step,
                                      output logic [63:0] sq);
        longint d;
        logic [63:0] mag;
        d = longint'(p) - longint'(grid >> 1);
        if (d < 0)
            d = -d;
        mag = 64'(d) * 64'(step);
        sq = '0;
        if (mag >= 64'h1_0000_0000)
            return 1'b0;
        sq = (mag * mag) >> 32;
        return 1'b1;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint sat_sample(input longint v);
        longint hi, lo;
        hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
        lo = -hi - 1;
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    // Phase-screen rotation of one pixel.
    function automatic res_t rotate_pixel(input pix_t p);
        res_t r;
        longint re, im, x, y, t, dx, dy, resid;
        logic [63:0] lx2, my2, r2, root, s, prod;
        logic [31:0] angle, z, q, rem;
        re = longint'(p.sample_real);
        im = longint'(p.sample_imag);
        r.result_real = p.sample_real;
        r.result_imag = p.sample_imag;
        if (sh_w == 0 || (re == 0 && im == 0))
            return r;
        if (!dir_cos_sq(p.pixel_x, sh_width, sh_step_x, lx2) ||
            !dir_cos_sq(p.pixel_y, sh_height, sh_step_y, my2))
            return r;
        r2 = lx2 + my2;
        if (r2 >= 64'h1_0000_0000)
            return r;
        root = (r2 == 0) ? 64'h1_0000_0000 : int_sqrt((64'h1_0000_0000 - r2) << 32);
        s = 64'h1_0000_0000 - root;
        prod = 64'(longint'($signed(sh_w))) * s;
        angle = 32'(((prod + (64'd1 << 27)) >> 28) & 64'hFFFF);
        z = 32'd0 - (angle << 16);
        q = ((z + 32'h2000_0000) >> 30) & 32'd3;
        rem = z - (q << 30);
        resid = longint'(rem);
        if (resid >= 64'sh8000_0000)
            resid -= 64'sh1_0000_0000;
        x = (re * longint'(INV_GAIN)) >>> (32 - GUARD);
        y = (im * longint'(INV_GAIN)) >>> (32 - GUARD);
        if (q == 1)
        begin
            t = x; x = -y; y = t;
        end
        else if (q == 2)
        begin
            x = -x; y = -y;
        end
        else if (q == 3)
        begin
            t = x; x = y; y = -t;
        end
        for (int k = 0; k < CORDIC_STAGES_DEF; k++)
        begin
            dx = y >>> k;
            dy = x >>> k;
            if (resid >= 0)
            begin
                x -= dx; y += dy; resid -= longint'(ARCTAN_Q32[k]);
            end
            else
            begin
                x += dx; y -= dy; resid += longint'(ARCTAN_Q32[k]);
            end
        end
        r.result_real = SAMPLE_BITS'(sat_sample((x + (longint'(1) <<< (GUARD - 1))) >>> GUARD));
        r.result_imag = SAMPLE_BITS'(sat_sample((y + (longint'(1) <<< (GUARD - 1))) >>> GUARD));
        return r;
    endfunction

    // Register write at the next rising edge; block must be idle.
    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_GRID_WIDTH:  sh_width  = val[GRID_BITS-1:0];
            REG_GRID_HEIGHT: sh_height = val[GRID_BITS-1:0];
            REG_CELL_STEP_X: sh_step_x = val;
            REG_CELL_STEP_Y: sh_step_y = val;
            REG_W_TURNS:     sh_w      = val;
            default: ;
        endcase
    endtask

    // Drop pix_valid after the last accepted transaction. Called at a falling edge.
    task automatic stop_sending();
        pix_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Wait until every expected pixel has come back, then let the pipe settle.
    task automatic drain();
        stop_sending();
        while (expected_pixels.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    // Send one pixel transaction. Called at a falling edge; returns at a falling edge
    // with pix_valid still high, so the next call can follow with no gap.
    // If a row expectation is given it is queued instead of the predicted value.
    task automatic send_pixel(input pix_t p, input bit use_given, input res_t given);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            pix_valid <= 1'b0;
            @(negedge clk);
        end
        pix_valid <= 1'b1;
        pix       <= p;
        do
            @(posedge clk);
        while (!pix_ready);
        expected_pixels.push_back(use_given ? given : rotate_pixel(p));
        @(negedge clk);
    endtask

    // Receiver: random back-pressure, checks each result transaction.
    always @(negedge clk)
        res_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: %h", res);
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (res.result_real !== want.result_real || res.result_imag !== want.result_imag)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected re %0d im %0d, got re %0d im %0d",
                                 want.result_real, want.result_imag,
                                 res.result_real, res.result_imag);
                end
            end
        end
    end

    // Directed rows: pixel, whether the expected value is given, and that value.
    typedef struct {
        pix_t p;
        bit   given;
        res_t want;
    } pix_row_t;

    function automatic pix_t mk(input int x, input int y, input int re, input int im);
        pix_t p;
        p.pixel_x = COORD_BITS'(x);
        p.pixel_y = COORD_BITS'(y);
        p.sample_real = SAMPLE_BITS'(re);
        p.sample_imag = SAMPLE_BITS'(im);
        return p;
    endfunction

    function automatic res_t mkr(input int re, input int im);
        res_t r;
        r.result_real = SAMPLE_BITS'(re);
        r.result_imag = SAMPLE_BITS'(im);
        return r;
    endfunction

    // Random pixel; samples lean toward extremes now and then.
    function automatic pix_t rand_pixel();
        pix_t p;
        p.pixel_x = COORD_BITS'($urandom);
        p.pixel_y = COORD_BITS'($urandom);
        case ($urandom_range(9))
            0: p.sample_real = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            1: p.sample_real = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            default: p.sample_real = SAMPLE_BITS'($urandom);
        endcase
        case ($urandom_range(9))
            0: p.sample_imag = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            1: p.sample_imag = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            2: p.sample_imag = '0;
            default: p.sample_imag = SAMPLE_BITS'($urandom);
        endcase
        if ($urandom_range(49) == 0)
        begin
            p.sample_real = '0;
            p.sample_imag = '0;
        end
        return p;
    endfunction

    // Random configuration. Cell steps mostly small so that r2 < 1 for most pixels,
    // otherwise the phase screen would almost always be bypassed.
    task automatic random_config();
        logic [31:0] sx, sy, w;
        case ($urandom_range(3))
            0: sx = $urandom;
            1: sx = $urandom_range(32'h0020_0000);
            default: sx = $urandom_range(32'h0010_0000);
        endcase
        sy = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0010_0000);
        case ($urandom_range(4))
            0: w = 32'h7FFF_FFFF;
            1: w = 32'h8000_0000;
            2: w = $urandom_range(32'h0010_0000);
            default: w = $urandom;
        endcase
        write_reg(REG_GRID_WIDTH,  ($urandom_range(3) == 0) ? $urandom_range(1, 8191)
                                                            : $urandom_range(1, 4096));
        write_reg(REG_GRID_HEIGHT, ($urandom_range(3) == 0) ? $urandom_range(0, 8191)
                                                            : $urandom_range(1, 4096));
        write_reg(REG_CELL_STEP_X, sx);
        write_reg(REG_CELL_STEP_Y, sy);
        write_reg(REG_W_TURNS,     w);
    endtask

    initial
    begin
        pix_row_t rows[$];
        res_t none;
        none = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // After reset the plane w is zero: every pixel passes unchanged.
        rows.push_back('{mk(0, 0, 8388607, -8388608), 1, mkr(8388607, -8388608)});
        rows.push_back('{mk(4095, 4095, -8388608, 8388607), 1, mkr(-8388608, 8388607)});
        rows.push_back('{mk(2048, 2048, 1, -1), 1, mkr(1, -1)});
        foreach (rows[i])
            send_pixel(rows[i].p, rows[i].given, rows[i].want);
        drain();
        rows.delete();

        // Screen active with small steps; centre pixel, zero sample, edges, extremes.
        write_reg(REG_GRID_WIDTH,  13'd4096);
        write_reg(REG_GRID_HEIGHT, 13'd4096);
        write_reg(REG_CELL_STEP_X, 32'h0008_0000);
        write_reg(REG_CELL_STEP_Y, 32'h0008_0000);
        write_reg(REG_W_TURNS,     32'h0012_3456);
        rows.push_back('{mk(2048, 2048, 1000000, -2000000), 0, none});
        rows.push_back('{mk(100, 3000, 0, 0), 1, mkr(0, 0)});
        rows.push_back('{mk(0, 0, 8388607, 8388607), 0, none});
        rows.push_back('{mk(4095, 0, -8388608, -8388608), 0, none});
        rows.push_back('{mk(0, 4095, 8388607, -8388608), 0, none});
        rows.push_back('{mk(1234, 2900, 555555, 4444), 0, none});
        rows.push_back('{mk(2049, 2047, -1, 1), 0, none});
        foreach (rows[i])
            send_pixel(rows[i].p, rows[i].given, rows[i].want);
        drain();
        rows.delete();

        // Cosine at or above one on an axis: unchanged. Extreme w, odd grid sizes.
        write_reg(REG_CELL_STEP_X, 32'hFFFF_FFFF);
        write_reg(REG_W_TURNS,     32'h8000_0000);
        write_reg(REG_GRID_WIDTH,  13'd1);
        rows.push_back('{mk(5, 2048, 123, -456), 1, mkr(123, -456)});
        rows.push_back('{mk(0, 2048, 123, -456), 0, none});
        foreach (rows[i])
            send_pixel(rows[i].p, rows[i].given, rows[i].want);
        drain();
        rows.delete();

        // r2 at or above one from the sum of two sub-unit cosines; grid size zero.
        write_reg(REG_CELL_STEP_X, 32'h0010_0000);
        write_reg(REG_CELL_STEP_Y, 32'h0010_0000);
        write_reg(REG_GRID_WIDTH,  13'd0);
        write_reg(REG_GRID_HEIGHT, 13'd0);
        write_reg(REG_W_TURNS,     32'h7FFF_FFFF);
        rows.push_back('{mk(3000, 3000, 7777, 8888), 1, mkr(7777, 8888)});
        rows.push_back('{mk(0, 0, 7777, 8888), 0, none});
        rows.push_back('{mk(1000, 2000, -7777, 8888), 0, none});
        foreach (rows[i])
            send_pixel(rows[i].p, rows[i].given, rows[i].want);
        drain();

        // Random part in three idle phases, with a config change every 50 transactions.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 8; recv_idle_pct = 50;
            end
            else if (n < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 50; recv_idle_pct = 8;
            end
            else
            begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            if (n % 50 == 0)
            begin
                drain();
                random_config();
            end
            else if (n % 173 == 0)
            begin
                // Sender holds off until everything in flight has returned.
                stop_sending();
                while (expected_pixels.size() != 0)
                    @(negedge clk);
            end
            send_pixel(rand_pixel(), 0, none);
        end

        drain();
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
